@@ rtl/rpn_stack_evaluator_assert.svh @@
// Assertion macros shared by the operand stack evaluator modules.
`ifndef RPN_STACK_EVALUATOR_ASSERT_SVH
`define RPN_STACK_EVALUATOR_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define RPN_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define RPN_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define RPN_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/rpn_pkg.sv @@
// Shared types, codes and constants of the operand stack evaluator.
package rpn_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam int WORD_W          = 32;

  localparam logic [2:0] CMD_PUSH = 3'd0;
  localparam logic [2:0] CMD_ADD  = 3'd1;
  localparam logic [2:0] CMD_SUB  = 3'd2;
  localparam logic [2:0] CMD_MUL  = 3'd3;
  localparam logic [2:0] CMD_DIV  = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_DIVZ  = 3'd3;
  localparam logic [2:0] ST_SAT   = 3'd4;

  localparam logic [WORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [2:0]               cmd;
    logic signed [WORD_W-1:0] operand_value;
  } in_req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] top_value;
    logic [4:0]               entry_count;
    logic [2:0]               status_code;
    logic                     is_void;
  } out_rsp_t;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] value;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [WORD_W-1:0] quot;
  } div_rsp_t;

endpackage

@@ rtl/rpn_front.sv @@
// Front end: takes requests and decodes each command into a queue entry.
module rpn_front import rpn_pkg::*; (
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  input  q_stat_t  q_stat,
  output logic     q_push,
  output q_entry_t q_wdata
);

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  always_comb begin
    q_wdata.value = in_req.operand_value;
    unique case (in_req.cmd)
      CMD_PUSH: q_wdata.op = OP_PUSH;
      CMD_ADD:  q_wdata.op = OP_ADD;
      CMD_SUB:  q_wdata.op = OP_SUB;
      CMD_MUL:  q_wdata.op = OP_MUL;
      CMD_DIV:  q_wdata.op = OP_DIV;
      default:  q_wdata.op = OP_NOP;
    endcase
  end

endmodule

@@ rtl/rpn_cmd_fifo.sv @@
// Short command queue between the front end and the execution back end.
`include "rpn_stack_evaluator_assert.svh"

module rpn_cmd_fifo import rpn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wdata,
  input  logic     pop,
  output q_entry_t rdata,
  output q_stat_t  stat
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  q_entry_t        slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            wr_en;
  logic            rd_en;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CW'(QUEUE_DEPTH));
  assign wr_en      = push && !stat.full;
  assign rd_en      = pop && !stat.empty;
  assign rdata      = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `RPN_CHECK(a_q_count_bound, cnt_r <= CW'(QUEUE_DEPTH), "queue count above depth")
  `RPN_CHECK(a_q_ptr_match, wr_ptr_r == PW'(rd_ptr_r + cnt_r), "queue pointers disagree with count")

endmodule

@@ rtl/rpn_div.sv @@
// Radix-2 restoring divider for the fixed-point quotient, one bit per cycle.
`include "rpn_stack_evaluator_assert.svh"

module rpn_div import rpn_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output div_rsp_t          rsp
);

  localparam int NW = WORD_W + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);
  localparam int HW = NW - WORD_W + 1;

  logic              busy_r;
  logic [CW-1:0]     cnt_r;
  logic [NW-1:0]     num_r;
  logic [WORD_W-1:0] den_r;
  logic [WORD_W-1:0] rem_r;
  logic              neg_r;

  logic [WORD_W-1:0] mag_s;
  logic [WORD_W-1:0] mag_t;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   rem_dif;
  logic              ge;
  logic [HW-1:0]     hi;
  logic              over;
  logic [WORD_W-1:0] quot_val;

  always_comb begin
    mag_s   = dividend[WORD_W-1] ? (~dividend + WORD_W'(1)) : dividend;
    mag_t   = divisor[WORD_W-1] ? (~divisor + WORD_W'(1)) : divisor;
    rem_sh  = {rem_r, num_r[NW-1]};
    rem_dif = rem_sh - {1'b0, den_r};
    ge      = (rem_sh >= {1'b0, den_r});
    hi      = num_r[NW-1:WORD_W-1];
    // The quotient register holds the magnitude; the negative range reaches one further.
    if (neg_r) begin
      over     = (hi > HW'(1)) || ((hi == HW'(1)) && (|num_r[WORD_W-2:0]));
      quot_val = over ? SAT_MIN : (~num_r[WORD_W-1:0] + WORD_W'(1));
    end else begin
      over     = |hi;
      quot_val = over ? SAT_MAX : num_r[WORD_W-1:0];
    end
  end

  assign rsp.done = busy_r && (cnt_r == '0);
  assign rsp.sat  = over;
  assign rsp.quot = quot_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
    end else if (busy_r && (cnt_r != '0)) begin
      cnt_r <= cnt_r - CW'(1);
    end else if (rsp.done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= NW'(mag_s) << FRAC_BITS;
      den_r <= mag_t;
      rem_r <= '0;
      neg_r <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
    end else if (busy_r && (cnt_r != '0)) begin
      num_r <= {num_r[NW-2:0], ge};
      rem_r <= ge ? rem_dif[WORD_W-1:0] : rem_sh[WORD_W-1:0];
    end
  end

  `RPN_CHECK_NOW(a_div_start_idle, start, !busy_r, "divide started while busy")

endmodule

@@ rtl/rpn_back.sv @@
// Back end: operand stack, arithmetic sequencer and result register.
`include "rpn_stack_evaluator_assert.svh"

module rpn_back import rpn_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  q_stat_t           q_stat,
  input  q_entry_t          q_rdata,
  output logic              q_pop,
  output logic              div_start,
  output logic [WORD_W-1:0] div_dividend,
  output logic [WORD_W-1:0] div_divisor,
  input  div_rsp_t          div_rsp,
  output logic              out_valid,
  input  logic              out_stall,
  output out_rsp_t          out_rsp
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int FW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    BK_IDLE = 4'b0001,
    BK_READ = 4'b0010,
    BK_MUL  = 4'b0100,
    BK_DIV  = 4'b1000
  } bk_state_t;

  bk_state_t                state_r, state_nxt;
  logic [FW-1:0]            fill_r, fill_nxt;
  logic signed [WORD_W-1:0] top_r, top_nxt;
  op_t                      op_r;
  logic [WORD_W-1:0]        mem [STACK_DEPTH];
  logic signed [WORD_W-1:0] rd_q_r;
  logic signed [63:0]       prod_r;
  logic                     out_valid_r, out_valid_nxt;
  out_rsp_t                 out_rsp_r, out_rsp_nxt;

  logic                     mem_we;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            rd_addr;
  logic                     load_out;
  logic [2:0]               status;
  logic                     finish;
  logic [WORD_W-1:0]        fin_val;
  logic [WORD_W:0]          sum;
  logic                     sum_sat;
  logic signed [63:0]       prod_sh;
  logic                     mul_sat;

  assign wr_addr      = AW'(fill_r - FW'(1));
  assign rd_addr      = AW'(fill_r - FW'(2));
  assign div_dividend = rd_q_r;
  assign div_divisor  = top_r;
  assign out_valid    = out_valid_r;
  assign out_rsp      = out_rsp_r;

  always_comb begin
    if (op_r == OP_SUB) begin
      sum = {rd_q_r[WORD_W-1], rd_q_r} - {top_r[WORD_W-1], top_r};
    end else begin
      sum = {rd_q_r[WORD_W-1], rd_q_r} + {top_r[WORD_W-1], top_r};
    end
    sum_sat = (sum[WORD_W] != sum[WORD_W-1]);
    prod_sh = prod_r >>> FRAC_BITS;
    mul_sat = !((&prod_sh[63:WORD_W-1]) || (~|prod_sh[63:WORD_W-1]));
  end

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    top_nxt   = top_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    mem_we    = 1'b0;
    load_out  = 1'b0;
    status    = ST_OK;
    finish    = 1'b0;
    fin_val   = '0;

    unique case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty && !out_valid_r) begin
          q_pop = 1'b1;
          case (q_rdata.op) inside
            OP_PUSH: begin
              load_out = 1'b1;
              if (fill_r == FW'(STACK_DEPTH)) begin
                status = ST_OVER;
              end else begin
                // The old top moves down into the memory; the new value stays cached.
                mem_we   = (fill_r != '0);
                top_nxt  = q_rdata.value;
                fill_nxt = fill_r + FW'(1);
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
              if (fill_r < FW'(2)) begin
                load_out = 1'b1;
                status   = ST_UNDER;
              end else begin
                state_nxt = BK_READ;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      BK_READ: begin
        case (op_r) inside
          OP_ADD, OP_SUB: begin
            finish  = 1'b1;
            fin_val = sum_sat ? (sum[WORD_W] ? SAT_MIN : SAT_MAX) : sum[WORD_W-1:0];
            status  = sum_sat ? ST_SAT : ST_OK;
          end
          OP_MUL: begin
            state_nxt = BK_MUL;
          end
          OP_DIV: begin
            if (top_r == '0) begin
              finish  = 1'b1;
              fin_val = rd_q_r[WORD_W-1] ? SAT_MIN : SAT_MAX;
              status  = ST_DIVZ;
            end else begin
              div_start = 1'b1;
              state_nxt = BK_DIV;
            end
          end
          default: begin
            state_nxt = BK_IDLE;
          end
        endcase
      end
      BK_MUL: begin
        finish  = 1'b1;
        fin_val = mul_sat ? (prod_sh[63] ? SAT_MIN : SAT_MAX) : prod_sh[WORD_W-1:0];
        status  = mul_sat ? ST_SAT : ST_OK;
      end
      BK_DIV: begin
        if (div_rsp.done) begin
          finish  = 1'b1;
          fin_val = div_rsp.quot;
          status  = div_rsp.sat ? ST_SAT : ST_OK;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    if (finish) begin
      top_nxt   = fin_val;
      fill_nxt  = fill_r - FW'(1);
      load_out  = 1'b1;
      state_nxt = BK_IDLE;
    end

    out_rsp_nxt.top_value   = (fill_nxt != '0) ? top_nxt : '0;
    out_rsp_nxt.entry_count = 5'(fill_nxt);
    out_rsp_nxt.status_code = status;
    out_rsp_nxt.is_void     = (fill_nxt == '0);

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= top_r;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    top_r  <= top_nxt;
    prod_r <= 64'(rd_q_r) * 64'(top_r);
    if (q_pop) begin
      op_r <= q_rdata.op;
    end
    if (load_out) begin
      out_rsp_r <= out_rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `RPN_CHECK(a_fill_bound, fill_r <= FW'(STACK_DEPTH), "entry count above stack depth")
  `RPN_CHECK_NOW(a_busy_no_result, state_r != BK_IDLE, !out_valid_r, "result pending during work")
  `RPN_CHECK_NEXT(a_div_pops_one, (state_r == BK_DIV) && div_rsp.done, fill_r == $past(fill_r) - FW'(1), "divide did not drop one entry")

endmodule

@@ rtl/rpn_stack_evaluator.sv @@
// Top level of the reverse-Polish operand stack evaluator.
//
// Each request carries a command and a signed Q16.16 operand (FRAC_BITS
// fraction bits). A push places the operand on a stack of STACK_DEPTH
// entries; add, subtract, multiply and divide pop the top (T) and the entry
// below it (S) and push S+T, S-T, S*T or S/T. Every request produces exactly
// one response with the new top (zero when empty), the entry count (low five
// bits), a status code and an empty flag. Status is underflow when an
// operator finds fewer than two entries (stack unchanged), overflow when a
// push meets a full stack (value dropped), divide by zero when T is zero (the
// result saturates toward the sign of S), and saturated when a sum, product
// or quotient leaves the 32-bit range and was clamped. Products round toward
// minus infinity and quotients truncate toward zero. Unknown commands leave
// the stack alone and report ok. Requests enter a four-entry command queue,
// so the input keeps accepting while a response waits for the consumer.
// The back end executes one command at a time and takes the next one only
// after the previous response has left the output register. A push is
// answered from the idle state, add and subtract after a registered read
// of the second entry, multiply after one registered multiply and then the
// shift and clamp, and divide when the radix-2 divider, which retires one
// quotient bit per cycle, is done. An output stall holds off the next
// command. The top of stack lives in a register and the deeper entries in
// a memory with one write and one registered read port; the memory is never
// cleared, because only entries that were written are ever read.
module rpn_stack_evaluator import rpn_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_rsp_t out_rsp
);

  // Queue handshake between the decoder and the sequencer.
  q_stat_t           q_stat;
  logic              q_push;
  logic              q_pop;
  q_entry_t          q_wdata;
  q_entry_t          q_rdata;

  // Divider hookup; the sequencer starts it and waits for done.
  logic              div_start;
  logic [WORD_W-1:0] div_dividend;
  logic [WORD_W-1:0] div_divisor;
  div_rsp_t          div_rsp;

  rpn_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  rpn_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  rpn_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .rsp      (div_rsp)
  );

  rpn_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_rsp      (div_rsp),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_rsp      (out_rsp)
  );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the reverse-Polish operand stack evaluator.
module tb_top;
  import rpn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The three command codes that the block does not define. They must leave
  // the stack alone and report ok.
  localparam logic [2:0] CMD_SPARE5 = 3'd5;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  localparam int RANDOM_REQUESTS = 1010;
  localparam int CALM_REQUESTS   = 150;   // the tail of the run has no idling
  localparam int SQUEEZE_AT      = 300;   // request index where the sink holds off
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 64;    // outlasts a divide at default size
  localparam int CYCLE_LIMIT     = 600_000;

  // Bounds of a stack entry, widened so that sums, products and quotients
  // can be compared against them before clamping.
  localparam longint WORD_HI = longint'(signed'(SAT_MAX));
  localparam longint WORD_LO = longint'(signed'(SAT_MIN));

  // Mix of commands used for one block of random requests.
  typedef enum int {
    MIX_BALANCED,
    MIX_FILL,
    MIX_DRAIN,
    MIX_SMALL
  } mix_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_rsp_t out_rsp;

  rpn_stack_evaluator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  always #5 clk = ~clk;

  // Shadow copy of the operand stack, updated once per accepted request.
  logic [WORD_W-1:0] shadow_stack [STACK_DEPTH_DEF];
  int                shadow_fill = 0;

  // Responses still owed by the block, oldest first.
  out_rsp_t awaited_results [$];

  int  failures = 0;
  int  requests_accepted = 0;
  int  directed_count = 0;
  int  responses_checked = 0;
  int  status_seen [8] = '{default: 0};
  int  cycle_count = 0;
  bit  squeeze_req = 1'b0;
  bit  calm_tail = 1'b0;

  // Directed table. Rows with a typed response carry a value that follows
  // directly from the stack contents at that point; the rest are checked
  // against the shadow stack. A row may repeat its request.
  typedef struct {
    in_req_t  req;
    int       reps;
    bit       typed;
    out_rsp_t rsp;
  } script_row_t;

  localparam int SCRIPT_LEN = 28;

  script_row_t script [SCRIPT_LEN] = '{
    // An operator on an empty stack underflows, and the empty flag is set.
    '{'{CMD_ADD,  32'h0000_0000}, 1, 1'b1, '{32'h0000_0000, 5'd0, ST_UNDER, 1'b1}},
    '{'{CMD_PUSH, 32'h8000_0000}, 1, 1'b1, '{32'h8000_0000, 5'd1, ST_OK, 1'b0}},
    // One entry is still too few for an operator.
    '{'{CMD_DIV,  32'h0000_0000}, 1, 1'b1, '{32'h8000_0000, 5'd1, ST_UNDER, 1'b0}},
    '{'{CMD_PUSH, 32'h0000_0000}, 1, 1'b0, '0},
    '{'{CMD_PUSH, 32'h7FFF_FFFF}, 14, 1'b0, '0},
    // The stack is full now, so this push is dropped.
    '{'{CMD_PUSH, 32'h0000_0001}, 1, 1'b1, '{32'h7FFF_FFFF, 5'd16, ST_OVER, 1'b0}},
    // Largest plus largest, then largest times largest, both clamp high.
    '{'{CMD_ADD,  32'h0000_0000}, 1, 1'b1, '{32'h7FFF_FFFF, 5'd15, ST_SAT, 1'b0}},
    '{'{CMD_MUL,  32'h0000_0000}, 1, 1'b1, '{32'h7FFF_FFFF, 5'd14, ST_SAT, 1'b0}},
    '{'{CMD_PUSH, 32'h8000_0000}, 1, 1'b0, '0},
    '{'{CMD_SUB,  32'h0000_0000}, 1, 1'b1, '{32'h7FFF_FFFF, 5'd14, ST_SAT, 1'b0}},
    '{'{CMD_PUSH, 32'h8000_0000}, 1, 1'b0, '0},
    '{'{CMD_MUL,  32'h0000_0000}, 1, 1'b1, '{32'h8000_0000, 5'd14, ST_SAT, 1'b0}},
    // Zero divisor under a negative dividend saturates low.
    '{'{CMD_PUSH, 32'h0000_0000}, 1, 1'b0, '0},
    '{'{CMD_DIV,  32'h0000_0000}, 1, 1'b1, '{32'h8000_0000, 5'd14, ST_DIVZ, 1'b0}},
    // Zero divisor under a positive dividend saturates high.
    '{'{CMD_PUSH, 32'h0003_0000}, 1, 1'b0, '0},
    '{'{CMD_PUSH, 32'h0000_0000}, 1, 1'b0, '0},
    '{'{CMD_DIV,  32'h0000_0000}, 1, 1'b1, '{32'h7FFF_FFFF, 5'd15, ST_DIVZ, 1'b0}},
    // Division by the smallest negative step overflows the quotient.
    '{'{CMD_PUSH, 32'hFFFF_FFFF}, 1, 1'b0, '0},
    '{'{CMD_DIV,  32'h0000_0000}, 1, 1'b0, '0},
    '{'{CMD_PUSH, 32'hFFFF_8000}, 1, 1'b0, '0},
    '{'{CMD_MUL,  32'h0000_0000}, 1, 1'b0, '0},
    // Undefined commands with assorted operands.
    '{'{CMD_SPARE5, 32'hFFFF_FFFF}, 1, 1'b0, '0},
    '{'{CMD_SPARE6, 32'h5A5A_5A5A}, 1, 1'b0, '0},
    '{'{CMD_SPARE7, 32'h0000_0000}, 1, 1'b0, '0},
    '{'{CMD_PUSH, 32'h0001_8000}, 1, 1'b0, '0},
    '{'{CMD_DIV,  32'h0000_0000}, 1, 1'b0, '0},
    '{'{CMD_SUB,  32'h0000_0000}, 1, 1'b0, '0},
    '{'{CMD_ADD,  32'h0000_0000}, 1, 1'b0, '0}
  };

  // Applies one accepted request to the shadow stack and returns the
  // response the block owes for it.
  function automatic out_rsp_t evaluate_command(input in_req_t req);
    logic signed [WORD_W-1:0] s;
    logic signed [WORD_W-1:0] t;
    logic [WORD_W-1:0]        r;
    logic [2:0]               status;
    longint                   wide;
    out_rsp_t                 rsp;
    status = ST_OK;
    r = '0;
    wide = 0;
    case (req.cmd) inside
      CMD_PUSH: begin
        if (shadow_fill >= STACK_DEPTH_DEF) begin
          status = ST_OVER;
        end else begin
          shadow_stack[shadow_fill] = req.operand_value;
          shadow_fill++;
        end
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
        if (shadow_fill < 2) begin
          status = ST_UNDER;
        end else begin
          t = shadow_stack[shadow_fill - 1];
          s = shadow_stack[shadow_fill - 2];
          if (req.cmd == CMD_DIV && t == 0) begin
            r = (s >= 0) ? SAT_MAX : SAT_MIN;
            status = ST_DIVZ;
          end else begin
            // Products shift arithmetically, which rounds toward minus
            // infinity; the signed divide truncates toward zero.
            case (req.cmd)
              CMD_ADD: wide = longint'(s) + longint'(t);
              CMD_SUB: wide = longint'(s) - longint'(t);
              CMD_MUL: wide = (longint'(s) * longint'(t)) >>> FRAC_BITS_DEF;
              default: wide = (longint'(s) <<< FRAC_BITS_DEF) / longint'(t);
            endcase
            if (wide > WORD_HI) begin
              r = SAT_MAX;
              status = ST_SAT;
            end else if (wide < WORD_LO) begin
              r = SAT_MIN;
              status = ST_SAT;
            end else begin
              r = wide[WORD_W-1:0];
            end
          end
          shadow_fill--;
          shadow_stack[shadow_fill - 1] = r;
        end
      end
      default: begin
      end
    endcase
    rsp.top_value   = (shadow_fill > 0) ? shadow_stack[shadow_fill - 1] : '0;
    rsp.entry_count = shadow_fill[4:0];
    rsp.status_code = status;
    rsp.is_void     = (shadow_fill == 0);
    return rsp;
  endfunction

  // Offers one request and waits for the block to take it. The response is
  // predicted at the edge of acceptance. Afterwards the source may go idle
  // for a short burst.
  task automatic issue_request(input in_req_t req, input bit has_typed,
                               input out_rsp_t typed_rsp);
    out_rsp_t predicted;
    int       gap;
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = evaluate_command(req);
    awaited_results.push_back(has_typed ? typed_rsp : predicted);
    requests_accepted++;
    if (!calm_tail && !squeeze_req && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      failures++;
    end
  endtask

  // Request source: reset, the directed table, then random requests in
  // blocks of fifty, each balanced or leaning toward one kind of traffic.
  // Filling blocks drive the stack into overflow, draining blocks into
  // underflow, and small-value blocks keep the arithmetic mostly in range.
  initial begin : request_source
    in_req_t req;
    mix_t    mix;
    int      pick;
    int      push_share;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (script[r]) begin
      repeat (script[r].reps) issue_request(script[r].req, script[r].typed, script[r].rsp);
    end
    directed_count = requests_accepted;
    mix = MIX_BALANCED;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 50 == 0) mix = mix_t'($urandom_range(MIX_BALANCED, MIX_SMALL));
      // Ask the sink to hold off; requests keep coming with no gaps until
      // it lets go, so the command queue fills and the input stalls.
      if (n == SQUEEZE_AT) squeeze_req = 1'b1;
      if (n == RANDOM_REQUESTS - CALM_REQUESTS) calm_tail = 1'b1;
      case (mix)
        MIX_FILL:  push_share = 80;
        MIX_DRAIN: push_share = 25;
        default:   push_share = 50;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < push_share) begin
        req.cmd = CMD_PUSH;
      end else if (pick < 96) begin
        req.cmd = 3'($urandom_range(CMD_ADD, CMD_DIV));
      end else begin
        req.cmd = 3'($urandom_range(CMD_SPARE5, CMD_SPARE7));
      end
      // Zeros feed the divide-by-zero case; the bounds feed saturation.
      pick = $urandom_range(0, 9);
      if (mix == MIX_SMALL && pick > 5) pick = 4;
      if (pick == 0) begin
        req.operand_value = '0;
      end else if (pick == 1) begin
        req.operand_value = SAT_MAX;
      end else if (pick == 2) begin
        req.operand_value = SAT_MIN;
      end else if (pick <= 5) begin
        req.operand_value = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      end else begin
        req.operand_value = $urandom;
      end
      issue_request(req, 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    // Any response that shows up now has no request behind it.
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests (%0d from the directed table), checked %0d responses.",
             requests_accepted, directed_count, responses_checked);
    $display("Statuses: ok %0d, underflow %0d, overflow %0d, divide by zero %0d, saturated %0d.",
             status_seen[ST_OK], status_seen[ST_UNDER], status_seen[ST_OVER],
             status_seen[ST_DIVZ], status_seen[ST_SAT]);
    if (failures == 0) begin
      $display("PASS rpn_stack_evaluator");
    end else begin
      $display("FAIL rpn_stack_evaluator");
    end
    $finish;
  end

  // Response sink: random stall bursts, one long hold-off on request, and
  // no stalls at all in the calm tail.
  initial begin : result_sink
    int burst;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        squeeze_req = 1'b0;
      end else if (!calm_tail && $urandom_range(0, 11) == 0) begin
        burst = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Every response taken from the block is matched against the oldest one
  // still owed, field by field.
  always @(posedge clk) begin : check_results
    out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected response, expected none, got %p", $time, out_rsp);
        failures++;
      end else begin
        want = awaited_results.pop_front();
        responses_checked++;
        status_seen[want.status_code]++;
        report_field("top_value", want.top_value, out_rsp.top_value);
        report_field("entry_count", 32'(want.entry_count), 32'(out_rsp.entry_count));
        report_field("status_code", 32'(want.status_code), 32'(out_rsp.status_code));
        report_field("is_void", 32'(want.is_void), 32'(out_rsp.is_void));
      end
    end
  end

  // Watchdog against a block that stops answering.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d responses owed.",
               cycle_count, awaited_results.size());
      $display("FAIL rpn_stack_evaluator");
      $finish;
    end
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rpn_pkg.sv
rtl/rpn_front.sv
rtl/rpn_cmd_fifo.sv
rtl/rpn_div.sv
rtl/rpn_back.sv
rtl/rpn_stack_evaluator.sv
tb/tb_top.sv
